FILE: hw/rtl/qrv_pkg.sv
package qrv_pkg;

    localparam int QUAT_W = 16;
    localparam int VEC_W  = 32;
    localparam int PROD_W = 2 * QUAT_W;        // one quaternion product
    localparam int MAT_W  = PROD_W + 2;        // rotation matrix entry, 2*(a-b)
    localparam int HALF_W = VEC_W / 2;         // vector split for the multipliers
    localparam int PLO_W  = MAT_W + HALF_W + 1;
    localparam int PHI_W  = MAT_W + HALF_W;
    localparam int PP_W   = MAT_W + VEC_W;     // one full matrix-vector product
    localparam int STAGES = 6;

    localparam logic [VEC_W-1:0] ROT_MAX = {1'b0, {(VEC_W - 1){1'b1}}};
    localparam logic [VEC_W-1:0] ROT_MIN = {1'b1, {(VEC_W - 1){1'b0}}};

    typedef logic signed [QUAT_W-1:0] t_quat;
    typedef logic signed [VEC_W-1:0]  t_vec;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [MAT_W-1:0]  t_mat;
    typedef logic signed [PLO_W-1:0]  t_plo;
    typedef logic signed [PHI_W-1:0]  t_phi;
    typedef logic signed [PP_W-1:0]   t_pp;

endpackage

FILE: hw/rtl/quaternion_rotate_vector.sv
// Rotates a Q16.16 vector by a Q2.14 quaternion: q * (v, 0) * conj(q), rounded and saturated.
// Throughput: one item per cycle while the output is not stalled; the six register stages (products,
// matrix, split multipliers, partial sum, row sum with rounding, saturation) each hold one item.
// Reset clears the stage valid bits only; data registers are not reset.
module quaternion_rotate_vector #(
    parameter int QUAT_FRAC_BITS = 14
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_quat_x,
    input  logic [15:0] i_quat_y,
    input  logic [15:0] i_quat_z,
    input  logic [15:0] i_quat_w,
    input  logic [31:0] i_vec_x,
    input  logic [31:0] i_vec_y,
    input  logic [31:0] i_vec_z,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_rot_x,
    output logic [31:0] o_rot_y,
    output logic [31:0] o_rot_z,
    output logic        o_saturated
);

    localparam int NST   = qrv_pkg::STAGES;
    localparam int SHIFT = 2 * QUAT_FRAC_BITS;
    localparam int ACC_W = (SHIFT + 33 > 68) ? SHIFT + 33 : 68;
    localparam int VW    = qrv_pkg::VEC_W;
    localparam int HW    = qrv_pkg::HALF_W;

    typedef logic signed [ACC_W-1:0] t_acc;

    localparam t_acc HALF = t_acc'(1) <<< (SHIFT - 1);

    // stage valid bits and per-stage advance
    logic [NST:1] r_vld;
    logic [NST:1] adv;

    always_comb begin
        adv[NST] = !r_vld[NST] || i_out_ready;
        for (int k = NST - 1; k >= 1; k--) begin
            adv[k] = !r_vld[k] || adv[k + 1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[1]) begin
                r_vld[1] <= i_in_valid;
            end
            for (int k = 2; k <= NST; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= r_vld[k - 1];
                end
            end
        end
    end

    assign o_in_ready  = adv[1];
    assign o_out_valid = r_vld[NST];

    // stage 1: quaternion products
    qrv_pkg::t_prod r_xx, r_yy, r_zz, r_ww, r_xy, r_xz, r_yz, r_wx, r_wy, r_wz;
    qrv_pkg::t_vec  r_v1 [3];

    qrv_pkg::t_quat qx, qy, qz, qw;
    assign qx = qrv_pkg::t_quat'(i_quat_x);
    assign qy = qrv_pkg::t_quat'(i_quat_y);
    assign qz = qrv_pkg::t_quat'(i_quat_z);
    assign qw = qrv_pkg::t_quat'(i_quat_w);

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r_xx    <= qx * qx;
            r_yy    <= qy * qy;
            r_zz    <= qz * qz;
            r_ww    <= qw * qw;
            r_xy    <= qx * qy;
            r_xz    <= qx * qz;
            r_yz    <= qy * qz;
            r_wx    <= qw * qx;
            r_wy    <= qw * qy;
            r_wz    <= qw * qz;
            r_v1[0] <= qrv_pkg::t_vec'(i_vec_x);
            r_v1[1] <= qrv_pkg::t_vec'(i_vec_y);
            r_v1[2] <= qrv_pkg::t_vec'(i_vec_z);
        end
    end

    // stage 2: rotation matrix
    qrv_pkg::t_mat r_m  [3][3];
    qrv_pkg::t_vec r_v2 [3];
    qrv_pkg::t_mat n_m  [3][3];
    qrv_pkg::t_mat exx, eyy, ezz, eww, exy, exz, eyz, ewx, ewy, ewz;

    always_comb begin
        exx = qrv_pkg::t_mat'(r_xx);
        eyy = qrv_pkg::t_mat'(r_yy);
        ezz = qrv_pkg::t_mat'(r_zz);
        eww = qrv_pkg::t_mat'(r_ww);
        exy = qrv_pkg::t_mat'(r_xy);
        exz = qrv_pkg::t_mat'(r_xz);
        eyz = qrv_pkg::t_mat'(r_yz);
        ewx = qrv_pkg::t_mat'(r_wx);
        ewy = qrv_pkg::t_mat'(r_wy);
        ewz = qrv_pkg::t_mat'(r_wz);
        n_m[0][0] = eww + exx - eyy - ezz;
        n_m[0][1] = (exy - ewz) <<< 1;
        n_m[0][2] = (exz + ewy) <<< 1;
        n_m[1][0] = (exy + ewz) <<< 1;
        n_m[1][1] = eww - exx + eyy - ezz;
        n_m[1][2] = (eyz - ewx) <<< 1;
        n_m[2][0] = (exz - ewy) <<< 1;
        n_m[2][1] = (eyz + ewx) <<< 1;
        n_m[2][2] = eww - exx - eyy + ezz;
    end

    always_ff @(posedge i_clk) begin
        if (adv[2]) begin
            r_m  <= n_m;
            r_v2 <= r_v1;
        end
    end

    // stage 3: matrix times low and high vector halves
    qrv_pkg::t_plo r_pl [3][3];
    qrv_pkg::t_phi r_ph [3][3];

    always_ff @(posedge i_clk) begin
        if (adv[3]) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_pl[i][j] <= r_m[i][j] * $signed({1'b0, r_v2[j][HW-1:0]});
                    r_ph[i][j] <= r_m[i][j] * $signed(r_v2[j][VW-1:HW]);
                end
            end
        end
    end

    // stage 4: recombine halves
    qrv_pkg::t_pp r_p [3][3];

    always_ff @(posedge i_clk) begin
        if (adv[4]) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_p[i][j] <= (qrv_pkg::t_pp'(r_ph[i][j]) <<< HW)
                               + qrv_pkg::t_pp'(r_pl[i][j]);
                end
            end
        end
    end

    // stage 5: row sums, round half up
    t_acc r_acc [3];

    always_ff @(posedge i_clk) begin
        if (adv[5]) begin
            for (int i = 0; i < 3; i++) begin
                r_acc[i] <= t_acc'(r_p[i][0]) + t_acc'(r_p[i][1])
                          + t_acc'(r_p[i][2]) + HALF;
            end
        end
    end

    // stage 6: scale down and clamp
    logic [VW-1:0] r_rot [3];
    logic          r_sat;
    logic [VW-1:0] n_rot [3];
    logic [2:0]    n_clip;
    t_acc          sh    [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sh[i] = r_acc[i] >>> SHIFT;
            if (&sh[i][ACC_W-1:VW-1] || !(|sh[i][ACC_W-1:VW-1])) begin
                n_rot[i]  = sh[i][VW-1:0];
                n_clip[i] = 1'b0;
            end else begin
                n_rot[i]  = r_acc[i][ACC_W-1] ? qrv_pkg::ROT_MIN : qrv_pkg::ROT_MAX;
                n_clip[i] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[6]) begin
            r_rot <= n_rot;
            r_sat <= |n_clip;
        end
    end

    assign o_rot_x     = r_rot[0];
    assign o_rot_y     = r_rot[1];
    assign o_rot_z     = r_rot[2];
    assign o_saturated = r_sat;

    // a clamp flag always comes with at least one rail value
    a_sat_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_saturated) |->
            (o_rot_x == qrv_pkg::ROT_MAX || o_rot_x == qrv_pkg::ROT_MIN ||
             o_rot_y == qrv_pkg::ROT_MAX || o_rot_y == qrv_pkg::ROT_MIN ||
             o_rot_z == qrv_pkg::ROT_MAX || o_rot_z == qrv_pkg::ROT_MIN))
        else $error("saturated flag without clamped component");

    // full pipe with stalled output must refuse input
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&r_vld && !i_out_ready) |-> !o_in_ready)
        else $error("input accepted into a full stalled pipeline");

    // an empty first stage never blocks input
    a_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[1] |-> o_in_ready)
        else $error("bubble not filled");

    // an item in the last-but-one stage reaches the output when it may advance
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NST - 1] && adv[NST]) |=> o_out_valid)
        else $error("item lost between last stages");

endmodule

FILE: bench/qrv_checker.sv
module qrv_checker #(
    parameter int QUAT_FRAC_BITS = 14
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_ready,
    input  qrv_pkg::t_quat i_quat_x,
    input  qrv_pkg::t_quat i_quat_y,
    input  qrv_pkg::t_quat i_quat_z,
    input  qrv_pkg::t_quat i_quat_w,
    input  qrv_pkg::t_vec  i_vec_x,
    input  qrv_pkg::t_vec  i_vec_y,
    input  qrv_pkg::t_vec  i_vec_z,
    input  logic           i_out_valid,
    input  logic           i_out_ready,
    input  qrv_pkg::t_vec  i_rot_x,
    input  qrv_pkg::t_vec  i_rot_y,
    input  qrv_pkg::t_vec  i_rot_z,
    input  logic           i_saturated,
    output int             o_fail_count,
    output int             o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SHIFT = 2 * QUAT_FRAC_BITS;
    localparam logic signed [79:0] ROUND_HALF = 80'sd1 <<< (SHIFT - 1);

    typedef struct packed {
        qrv_pkg::t_vec x;
        qrv_pkg::t_vec y;
        qrv_pkg::t_vec z;
        logic          sat;
    } t_rot;

    t_rot expected_rot[$];

    // one row of M * v, rounded half up, scaled back and clamped
    function automatic qrv_pkg::t_vec round_clamp(input longint m0, input longint m1,
                                                  input longint m2, input qrv_pkg::t_vec a,
                                                  input qrv_pkg::t_vec b,
                                                  input qrv_pkg::t_vec c,
                                                  inout logic sat);
        logic signed [79:0] acc;
        acc = 80'(m0) * 80'(a) + 80'(m1) * 80'(b) + 80'(m2) * 80'(c);
        acc = (acc + ROUND_HALF) >>> SHIFT;
        if (acc > 80'sd2147483647) begin
            sat = 1'b1;
            return qrv_pkg::ROT_MAX;
        end
        if (acc < -80'sd2147483648) begin
            sat = 1'b1;
            return qrv_pkg::ROT_MIN;
        end
        return qrv_pkg::t_vec'(acc[31:0]);
    endfunction

    function automatic t_rot rotate_vector(input qrv_pkg::t_quat qx, input qrv_pkg::t_quat qy,
                                           input qrv_pkg::t_quat qz, input qrv_pkg::t_quat qw,
                                           input qrv_pkg::t_vec vx, input qrv_pkg::t_vec vy,
                                           input qrv_pkg::t_vec vz);
        longint x;
        longint y;
        longint z;
        longint w;
        logic   sat;
        t_rot   r;
        x = qx;
        y = qy;
        z = qz;
        w = qw;
        sat = 1'b0;
        r.x = round_clamp(w*w + x*x - y*y - z*z, 2 * (x*y - w*z), 2 * (x*z + w*y),
                          vx, vy, vz, sat);
        r.y = round_clamp(2 * (x*y + w*z), w*w - x*x + y*y - z*z, 2 * (y*z - w*x),
                          vx, vy, vz, sat);
        r.z = round_clamp(2 * (x*z - w*y), 2 * (y*z + w*x), w*w - x*x - y*y + z*z,
                          vx, vy, vz, sat);
        r.sat = sat;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_rot got;
        t_rot want;
        if (!i_rst_n) begin
            expected_rot.delete();
            o_outstanding = 0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                expected_rot.push_back(rotate_vector(i_quat_x, i_quat_y, i_quat_z, i_quat_w,
                                                     i_vec_x, i_vec_y, i_vec_z));
            end
            if (i_out_valid && i_out_ready) begin
                got = '{i_rot_x, i_rot_y, i_rot_z, i_saturated};
                if (expected_rot.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10) begin
                        $display("%0t: result with no item pending: x=%h y=%h z=%h sat=%b",
                                 $realtime, got.x, got.y, got.z, got.sat);
                    end
                end else begin
                    want = expected_rot.pop_front();
                    if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
                        got.sat !== want.sat) begin
                        o_fail_count++;
                        if (o_fail_count <= 10) begin
                            $display("%0t: mismatch exp x=%h y=%h z=%h sat=%b",
                                     $realtime, want.x, want.y, want.z, want.sat);
                            $display("%0t:          got x=%h y=%h z=%h sat=%b",
                                     $realtime, got.x, got.y, got.z, got.sat);
                        end
                    end
                end
            end
            o_outstanding = expected_rot.size();
        end
    end

endmodule

FILE: bench/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 500;
    localparam int QUIET_FROM   = 420;

    logic           i_clk = 1'b0;
    logic           i_rst_n;
    logic           i_in_valid;
    logic           o_in_ready;
    qrv_pkg::t_quat i_quat_x;
    qrv_pkg::t_quat i_quat_y;
    qrv_pkg::t_quat i_quat_z;
    qrv_pkg::t_quat i_quat_w;
    qrv_pkg::t_vec  i_vec_x;
    qrv_pkg::t_vec  i_vec_y;
    qrv_pkg::t_vec  i_vec_z;
    logic           o_out_valid;
    logic           i_out_ready;
    qrv_pkg::t_vec  o_rot_x;
    qrv_pkg::t_vec  o_rot_y;
    qrv_pkg::t_vec  o_rot_z;
    logic           o_saturated;
    int             fail_count;
    int             outstanding;
    bit             quiet_tail;

    quaternion_rotate_vector u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_quat_x    (i_quat_x),
        .i_quat_y    (i_quat_y),
        .i_quat_z    (i_quat_z),
        .i_quat_w    (i_quat_w),
        .i_vec_x     (i_vec_x),
        .i_vec_y     (i_vec_y),
        .i_vec_z     (i_vec_z),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_rot_x     (o_rot_x),
        .o_rot_y     (o_rot_y),
        .o_rot_z     (o_rot_z),
        .o_saturated (o_saturated)
    );

    qrv_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_quat_x      (i_quat_x),
        .i_quat_y      (i_quat_y),
        .i_quat_z      (i_quat_z),
        .i_quat_w      (i_quat_w),
        .i_vec_x       (i_vec_x),
        .i_vec_y       (i_vec_y),
        .i_vec_z       (i_vec_z),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_rot_x       (o_rot_x),
        .i_rot_y       (o_rot_y),
        .i_rot_z       (o_rot_z),
        .i_saturated   (o_saturated),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

    // called and returning at a falling edge
    task automatic send_rotation(input qrv_pkg::t_quat qx, input qrv_pkg::t_quat qy,
                                 input qrv_pkg::t_quat qz, input qrv_pkg::t_quat qw,
                                 input qrv_pkg::t_vec vx, input qrv_pkg::t_vec vy,
                                 input qrv_pkg::t_vec vz);
        i_in_valid = 1'b1;
        i_quat_x   = qx;
        i_quat_y   = qy;
        i_quat_z   = qz;
        i_quat_w   = qw;
        i_vec_x    = vx;
        i_vec_y    = vy;
        i_vec_z    = vz;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
    endtask

    task automatic drain_results();
        i_in_valid = 1'b0;
        while (outstanding != 0) @(negedge i_clk);
    endtask

    function automatic qrv_pkg::t_quat quat_corner();
        case ($urandom_range(0, 4))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh4000;
            3: return 16'shC000;
            default: return 16'sh0000;
        endcase
    endfunction

    function automatic qrv_pkg::t_vec vec_corner();
        case ($urandom_range(0, 3))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return 32'sh0000_0000;
            default: return qrv_pkg::t_vec'($urandom());
        endcase
    endfunction

    function automatic qrv_pkg::t_quat quat_unitish();
        return qrv_pkg::t_quat'(int'($urandom_range(0, 32768)) - 16384);
    endfunction

    function automatic qrv_pkg::t_vec vec_moderate();
        return qrv_pkg::t_vec'(int'($urandom_range(0, 33554431)) - 16777216);
    endfunction

    initial begin
        quiet_tail  = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_quat_x    = '0;
        i_quat_y    = '0;
        i_quat_z    = '0;
        i_quat_w    = '0;
        i_vec_x     = '0;
        i_vec_y     = '0;
        i_vec_z     = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // identity, zero quaternion, quarter turns about each axis, a half turn about x
        send_rotation(0, 0, 0, 16384, 32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000);
        send_rotation(0, 0, 0, 16384, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0000);
        send_rotation(0, 0, 0, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh1234_5678);
        send_rotation(0, 0, 11585, 11585, 32'sh0001_0000, 32'sh0000_0000, 32'sh0000_0000);
        send_rotation(11585, 0, 0, 11585, 32'sh0000_0000, 32'sh0001_0000, 32'sh0000_0000);
        send_rotation(0, 11585, 0, 11585, 32'sh0000_0000, 32'sh0000_0000, 32'sh0001_0000);
        send_rotation(16384, 0, 0, 0, 32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000);
        // ties round toward plus infinity
        send_rotation(0, 0, 0, 1, 32'sh0800_0000, -32'sh0800_0000, 32'sh1800_0000);
        send_rotation(0, 0, 0, -1, 32'sh0800_0000, -32'sh0800_0000, -32'sh1800_0000);
        // saturation both ways, and exactly at the negative limit
        send_rotation(0, 0, 0, 32767, 32'sh7FFF_FFFF, 32'sh0000_0000, 32'sh0000_0001);
        send_rotation(0, 0, 0, 32767, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
        send_rotation(0, 0, 0, -32768, 32'sh2000_0000, 32'shE000_0000, 32'sh1FFF_FFFF);
        send_rotation(-32768, -32768, -32768, -32768,
                      32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_rotation(32767, 32767, 32767, 32767,
                      32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
        send_rotation(32767, -32768, 32767, -32768,
                      32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
        send_rotation(1, 2, 3, 4, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0001);
        send_rotation(-1, -1, -1, -1, 32'shFFFF_FFFF, 32'shFFFF_FFFF, 32'shFFFF_FFFF);
        drain_results();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2) drain_results();
            if (n == QUIET_FROM) quiet_tail = 1'b1;
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                    send_rotation(quat_unitish(), quat_unitish(), quat_unitish(),
                                  quat_unitish(), vec_moderate(), vec_moderate(),
                                  vec_moderate());
                4, 5, 6:
                    send_rotation(qrv_pkg::t_quat'($urandom()), qrv_pkg::t_quat'($urandom()),
                                  qrv_pkg::t_quat'($urandom()), qrv_pkg::t_quat'($urandom()),
                                  qrv_pkg::t_vec'($urandom()), qrv_pkg::t_vec'($urandom()),
                                  qrv_pkg::t_vec'($urandom()));
                7:
                    send_rotation(qrv_pkg::t_quat'($urandom()), qrv_pkg::t_quat'($urandom()),
                                  qrv_pkg::t_quat'($urandom()), qrv_pkg::t_quat'($urandom()),
                                  vec_corner(), vec_corner(), vec_corner());
                8:
                    send_rotation(quat_corner(), quat_corner(), quat_corner(),
                                  quat_corner(), qrv_pkg::t_vec'($urandom()),
                                  qrv_pkg::t_vec'($urandom()), qrv_pkg::t_vec'($urandom()));
                default:
                    send_rotation($urandom_range(0, 1) ? quat_unitish() : qrv_pkg::t_quat'(0),
                                  $urandom_range(0, 1) ? quat_unitish() : qrv_pkg::t_quat'(0),
                                  $urandom_range(0, 1) ? quat_unitish() : qrv_pkg::t_quat'(0),
                                  quat_unitish(), vec_moderate(), vec_moderate(),
                                  vec_moderate());
            endcase
        end

        drain_results();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

    initial begin
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (!quiet_tail && $urandom_range(0, 2) == 0) begin
                i_out_ready = 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge i_clk);
            end
            i_out_ready = 1'b1;
            repeat ($urandom_range(1, 30)) @(negedge i_clk);
        end
    end

endmodule

FILE: filelist.f
hw/rtl/qrv_pkg.sv
hw/rtl/quaternion_rotate_vector.sv
bench/qrv_checker.sv
bench/tb_top.sv
